// File: hw/rtl/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg: shared definitions for the tap tempo estimator
// Field widths, tempo constants, register indexes and the result record.
// ----------------------------------------------------------------------------
package tte_pkg;

    // Field widths.
    localparam int TIME_W      = 32;
    localparam int BPM_W       = 10;
    localparam int OUT_TDATA_W = 16;

    // Beats per minute from a millisecond interval.
    localparam int unsigned BPM_NUMERATOR = 60000;
    localparam int unsigned SLOW_LIMIT    = 30;
    // Largest interval whose tempo quotient still exceeds the slow limit.
    localparam int unsigned CLOSE_MAX_MS  = BPM_NUMERATOR / (SLOW_LIMIT + 1);

    // Configuration register indexes.
    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] REG_BPM_LO = 1'b0;
    localparam logic [CFG_AW-1:0] REG_BPM_HI = 1'b1;

    // Register reset values.
    localparam logic [BPM_W-1:0] BPM_LO_RST = 10'd60;
    localparam logic [BPM_W-1:0] BPM_HI_RST = 10'd400;

    // One result item, valid flag in the lowest bit.
    typedef struct packed {
        logic [BPM_W-1:0] bpm;
        logic             valid;
    } t_result;

endpackage

// File: hw/rtl/tte_div.sv
// ----------------------------------------------------------------------------
// tte_div: bit-serial restoring divider
// Produces one quotient bit per cycle; the divisor is a full tap time span.
// ----------------------------------------------------------------------------
module tte_div
    import tte_pkg::*;
#(
    parameter int NUM_W = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_numer,
    input  logic [TIME_W-1:0] i_denom,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_den;
    logic [NUM_W-1:0]  r_quo;

    logic [TIME_W:0]   w_trial;
    logic [TIME_W:0]   w_diff;
    logic              w_fit;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fit   = ~w_diff[TIME_W];

    // Control: iteration counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient register doubles as the dividend shifter.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_denom;
            r_quo <= i_numer;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[TIME_W-1:0] : w_trial[TIME_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// File: hw/rtl/tap_tempo_estimator.sv
// ----------------------------------------------------------------------------
// tap_tempo_estimator: tempo in beats per minute from a stream of tap times
// Keeps the most recent tap times; for each close tap with a nonzero span it
// divides 60000 times the interval count by the span to the oldest kept tap.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer contents
//  s_*       in         tdata[31:0] tap_time_ms
//  m_*       out        tuser[0] tempo_valid, tdata[9:0] tempo_bpm, [15:10] zero
//  cfg_*     in         addr 0 lowest tempo, addr 1 highest tempo, wdata[9:0]
//
//  A close tap with a nonzero span is accepted, then goes through the NUM_W-bit
//  serial divider (18 bits at TAP_DEPTH = 4) and ST_DONE into the output register;
//  other taps pass from acceptance through ST_DONE. The divider sets the rate.
//  Reset clears the tap count and loads the limits with 60 and 400.
//  The output register holds a result under back-pressure; the next tap is
//  taken once the previous one is finished, even while its result waits.
// ----------------------------------------------------------------------------
module tap_tempo_estimator
    import tte_pkg::*;
#(
    parameter int TAP_DEPTH = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Tap input stream.
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [TIME_W-1:0]      i_s_tdata,   // [31:0] tap_time_ms
    // Tempo output stream.
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [9:0] tempo_bpm
    output logic                   o_m_tuser,   // [0] tempo_valid
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_AW-1:0]      i_cfg_addr,
    input  logic [BPM_W-1:0]       i_cfg_wdata
);

    localparam int CNT_W    = $clog2(TAP_DEPTH + 1);
    localparam int IDX_W    = $clog2(TAP_DEPTH);
    localparam int NUM_MAX  = BPM_NUMERATOR * (TAP_DEPTH - 1);
    localparam int NUM_W    = $clog2(NUM_MAX + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [TIME_W-1:0] r_last;
    logic [TIME_W-1:0] r_times [TAP_DEPTH];
    logic [BPM_W-1:0]  r_bpm_lo;
    logic [BPM_W-1:0]  r_bpm_hi;
    t_result           r_res;
    t_result           r_out_res;
    logic              r_out_valid;

    logic              w_accept;
    logic [TIME_W-1:0] w_interval;
    logic              w_close;
    logic              w_close_tap;
    logic              w_shift;
    logic [TIME_W-1:0] w_oldest;
    logic [TIME_W-1:0] w_span;
    logic              w_span_zero;
    logic [CNT_W-1:0]  w_cnt_m1;
    logic [IDX_W-1:0]  w_wr_idx;
    logic [NUM_W-1:0]  w_numer;
    logic              w_div_start;
    logic              w_div_done;
    logic [NUM_W-1:0]  w_quot;
    logic [NUM_W-1:0]  w_clamp;
    logic              w_out_free;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || i_m_tready;

    // Closeness of the new tap to the newest kept one.
    assign w_interval = i_s_tdata - r_last;
    assign w_close    = (w_interval <= TIME_W'(CLOSE_MAX_MS));

    // Next tap count and whether the kept times slide down one place.
    always_comb begin
        n_count     = r_count;
        w_shift     = 1'b0;
        w_close_tap = 1'b0;
        w_oldest    = r_times[0];
        if (r_count == '0) begin
            n_count = CNT_W'(1);
        end else if (w_close) begin
            w_close_tap = 1'b1;
            if (r_count == CNT_W'(TAP_DEPTH)) begin
                w_shift  = 1'b1;
                w_oldest = r_times[1];
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            n_count = CNT_W'(1);
        end
    end

    assign w_cnt_m1    = n_count - 1'b1;
    assign w_wr_idx    = w_cnt_m1[IDX_W-1:0];
    assign w_span      = i_s_tdata - w_oldest;
    assign w_span_zero = (w_span == '0);
    assign w_numer     = NUM_W'(BPM_NUMERATOR * 32'(w_cnt_m1));
    assign w_div_start = w_accept && w_close_tap && !w_span_zero;

    // Tap time store; entries are written before they are ever read.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (w_shift) begin
                for (int i = 0; i < TAP_DEPTH - 1; i++) begin
                    r_times[i] <= r_times[i+1];
                end
            end
            r_times[w_wr_idx] <= i_s_tdata;
            r_last            <= i_s_tdata;
        end
    end

    // Tap count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpm_lo <= BPM_LO_RST;
            r_bpm_hi <= BPM_HI_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_BPM_LO: r_bpm_lo <= i_cfg_wdata;
                REG_BPM_HI: r_bpm_hi <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Serial divider for the tempo quotient.
    tte_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_numer (w_numer),
        .i_denom (w_span),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Clamp the quotient to the low limit first, then the high limit.
    always_comb begin
        w_clamp = w_quot;
        if (w_clamp < NUM_W'(r_bpm_lo)) begin
            w_clamp = NUM_W'(r_bpm_lo);
        end
        if (w_clamp > NUM_W'(r_bpm_hi)) begin
            w_clamp = NUM_W'(r_bpm_hi);
        end
    end

    // Sequencer: accept, divide if the tap starts a division, then hand the result to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= w_div_start ? ST_DIV : ST_DONE;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Pending result of the tap in progress.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res.valid <= w_close_tap;
            r_res.bpm   <= w_close_tap ? r_bpm_hi : '0;
        end else if (w_div_done) begin
            r_res.valid <= 1'b1;
            r_res.bpm   <= w_clamp[BPM_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_res <= r_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - BPM_W){1'b0}}, r_out_res.bpm};
    assign o_m_tuser  = r_out_res.valid;

    // A taken tap always leaves the idle state.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("tap accepted but sequencer stayed idle");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    // The tap count never exceeds the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TAP_DEPTH))
        else $error("tap count beyond store depth");

    // A result without a tempo carries a zero tempo.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_res.valid) |-> (r_out_res.bpm == '0))
        else $error("tempo field nonzero on a result without a tempo");

    // Only a close tap with a prior tap can start a division.
    a_start_needs_prior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (r_count != '0))
        else $error("division started on a first tap");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the tap tempo estimator
// Feeds tap timestamps through the input stream, predicts every tempo
// result from a local copy of the tap store and the tempo limits, and checks
// each output transfer in order. The run moves through several limit
// settings and several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import tte_pkg::*;

    localparam int TAP_DEPTH   = 4;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 60;

    // Clock, reset and block ports.
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [TIME_W-1:0]      i_s_tdata   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_AW-1:0]      i_cfg_addr  = REG_BPM_LO;
    logic [BPM_W-1:0]       i_cfg_wdata = '0;

    // Pending tap times and expected tempo results.
    logic [TIME_W-1:0] tap_queue[$];
    t_result           tempo_queue[$];

    // Taps put on the bus and taps taken by the block.
    int offered = 0;
    int taken   = 0;

    // Local copy of the block's state and limits.
    logic [TIME_W-1:0] kept_times[TAP_DEPTH];
    int                kept_count = 0;
    logic [BPM_W-1:0]  lim_min    = BPM_LO_RST;
    logic [BPM_W-1:0]  lim_max    = BPM_HI_RST;

    // Traffic shaping.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_req     = 1'b0;
    int hold_left      = 0;

    int error_count = 0;
    int cycle_count = 0;
    logic [TIME_W-1:0] cursor = '0;

    tap_tempo_estimator #(
        .TAP_DEPTH(TAP_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Tempo for one tap; updates the local tap store and count.
    function automatic t_result predict_tempo(input logic [TIME_W-1:0] now);
        t_result           res;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] span;
        logic [63:0]       bpm;
        res = '0;
        if (kept_count == 0) begin
            kept_count = 1;
        end else begin
            gap = now - kept_times[kept_count-1];
            if (gap == 0 || (BPM_NUMERATOR / gap) > SLOW_LIMIT) begin
                // A full store drops its oldest time.
                if (kept_count == TAP_DEPTH) begin
                    for (int i = 0; i < TAP_DEPTH - 1; i++) kept_times[i] = kept_times[i+1];
                end else begin
                    kept_count++;
                end
                span = now - kept_times[0];
                if (span == 0) begin
                    bpm = 64'(lim_max);
                end else begin
                    bpm = (64'(BPM_NUMERATOR) * 64'(kept_count - 1)) / 64'(span);
                end
                if (bpm < 64'(lim_min)) bpm = 64'(lim_min);
                if (bpm > 64'(lim_max)) bpm = 64'(lim_max);
                res.valid = 1'b1;
                res.bpm   = bpm[BPM_W-1:0];
            end else begin
                // A late tap restarts the sequence.
                kept_count = 1;
            end
        end
        kept_times[kept_count-1] = now;
        return res;
    endfunction

    // Tap driver: offers queued times and predicts each accepted transfer.
    always @(posedge i_clk) begin : drive_taps
        logic accepted;
        accepted = i_s_tvalid && o_s_tready;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (accepted) begin
                tempo_queue.push_back(predict_tempo(i_s_tdata));
                taken++;
            end
            if (!i_s_tvalid || accepted) begin
                if (tap_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= tap_queue.pop_front();
                    offered++;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here once requested.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            hold_left <= LONG_HOLD;
        end
    end

    // Result monitor: checks each output transfer against the oldest expectation.
    always @(posedge i_clk) begin : check_tempo
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (tempo_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_m_tdata);
                error_count++;
            end else begin
                want = tempo_queue.pop_front();
                if (o_m_tuser !== want.valid) begin
                    $display("%0t: tempo_valid expected %b, actual %b",
                             $time, want.valid, o_m_tuser);
                    error_count++;
                end
                if (o_m_tdata[BPM_W-1:0] !== want.bpm) begin
                    $display("%0t: tempo_bpm expected %0d, actual %0d",
                             $time, want.bpm, o_m_tdata[BPM_W-1:0]);
                    error_count++;
                end
                if (o_m_tdata[OUT_TDATA_W-1:BPM_W] !== '0) begin
                    $display("%0t: padding expected 0, actual %h",
                             $time, o_m_tdata[OUT_TDATA_W-1:BPM_W]);
                    error_count++;
                end
            end
        end
        i_m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Register write; the block is idle whenever this is called.
    task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [BPM_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        if (addr == REG_BPM_LO) lim_min = data;
        else lim_max = data;
    endtask

    task automatic set_limits(input logic [BPM_W-1:0] lo, input logic [BPM_W-1:0] hi);
        cfg_write(REG_BPM_LO, lo);
        cfg_write(REG_BPM_HI, hi);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every tap has gone in and every result has come out.
    task automatic wait_drained();
        while (tap_queue.size() != 0 || offered != taken || tempo_queue.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic push_tap(input logic [TIME_W-1:0] t);
        cursor = t;
        tap_queue.push_back(t);
    endtask

    // Mostly runs of close taps from a random start, plus late taps and noise.
    task automatic queue_random_taps(input int count);
        int pushed;
        int kind;
        int run_len;
        int pick;
        pushed = 0;
        while (pushed < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                if ($urandom_range(0, 9) == 0) push_tap(32'hFFFF_FFFF - $urandom_range(0, 3000));
                else push_tap($urandom());
                pushed++;
                run_len = $urandom_range(1, 8);
                for (int k = 0; k < run_len; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 10) push_tap(cursor + $urandom_range(0, 3));
                    else if (pick < 20) push_tap(cursor + $urandom_range(1900, 1935));
                    else push_tap(cursor + $urandom_range(150, 1200));
                    pushed++;
                end
            end else if (kind < 88) begin
                if ($urandom_range(0, 3) == 0) push_tap(cursor + 1936);
                else push_tap(cursor + $urandom_range(1936, 100000));
                pushed++;
            end else begin
                push_tap($urandom());
                pushed++;
            end
        end
    endtask

    // Stimulus sequence.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed taps at the reset limits.
        push_tap(32'h0000_0000);           // first tap
        push_tap(32'h0000_0000);           // zero interval, zero span
        push_tap(cursor + 1935);           // longest close interval
        push_tap(cursor + 1936);           // shortest late interval
        push_tap(cursor + 500);
        push_tap(cursor + 500);
        push_tap(cursor + 500);            // store now full
        push_tap(cursor + 500);            // oldest time dropped
        push_tap(cursor + 1);
        push_tap(cursor);
        push_tap(cursor);                  // tempo above the upper limit
        push_tap(cursor);                  // zero span with a full store
        push_tap(32'hFFFF_FFFF);
        push_tap(cursor + 300);            // timestamp wraps
        push_tap(cursor + 301);
        push_tap(cursor + 1935);
        push_tap(cursor + 1935);           // tempo below the lower limit
        push_tap(32'hFFFF_FFFF);
        push_tap(32'hAAAA_AAAA);
        push_tap(32'h5555_5555);
        push_tap(cursor + 1000);
        wait_drained();

        // Widest limits, no idling.
        set_limits(10'd1, 10'd1023);
        queue_random_taps(250);
        wait_drained();

        // Lower limit above the upper one, sender idling.
        set_limits(10'd1023, 10'd1);
        send_idle_pct = 45;
        queue_random_taps(150);
        wait_drained();

        // Both limits zero, receiver stalling.
        set_limits(10'd0, 10'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 45;
        queue_random_taps(60);
        wait_drained();

        // Reset limits again, both sides idling, with a long output hold-off.
        set_limits(BPM_LO_RST, BPM_HI_RST);
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        queue_random_taps(250);
        hold_req = 1'b1;
        while (hold_left == 0) @(posedge i_clk);
        hold_req = 1'b0;
        wait_drained();

        // Random limits; the sender pauses halfway until all results are in.
        set_limits(10'($urandom_range(1, 300)), 10'($urandom_range(300, 1023)));
        send_idle_pct  = 0;
        recv_stall_pct = 45;
        queue_random_taps(120);
        wait_drained();
        queue_random_taps(130);
        wait_drained();

        // Widest limits once more, both sides idling.
        set_limits(10'd1, 10'd1023);
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        queue_random_taps(250);
        wait_drained();

        // Let any stray result show up before the verdict.
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/tte_pkg.sv
hw/rtl/tte_div.sv
hw/rtl/tap_tempo_estimator.sv
verif/testbench.sv
